### hw/rtl/trs_pkg.sv
// trs_pkg: shared types and constants of the trap reaction selector
// depends on nothing; imported by trap_reaction_selector_core
`default_nettype none

package trs_pkg;

  // configuration port
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam logic        REG_ACTIVE_SITES = 1'b0;  // register index, paddr[2]
  localparam logic [9:0]  ACTIVE_SITES_RST = 10'd512;

  // field widths fixed at the ports
  localparam int unsigned SITE_FIELD_W  = 9;
  localparam int unsigned COUNT_FIELD_W = 10;
  localparam int unsigned RATE_FIELD_W  = 32;
  localparam int unsigned FRAC_W        = 32;

  // operation codes
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_EVENT = 1'b1;

  // sequencer states, one-hot
  typedef enum logic [9:0] {
    ST_CLEAR  = 10'b00_0000_0001,
    ST_IDLE   = 10'b00_0000_0010,
    ST_LD_RD  = 10'b00_0000_0100,
    ST_LD_WR  = 10'b00_0000_1000,
    ST_MUL_LO = 10'b00_0001_0000,
    ST_MUL_HI = 10'b00_0010_0000,
    ST_THR    = 10'b00_0100_0000,
    ST_SCAN   = 10'b00_1000_0000,
    ST_FLIP   = 10'b01_0000_0000,
    ST_EMIT   = 10'b10_0000_0000
  } trs_state_t;

endpackage

`default_nettype wire

### hw/rtl/trs_ram.sv
// trs_ram: generic simple dual-port ram, one write and one registered read port
// depends on nothing
`default_nettype none

module trs_ram #(
  parameter int unsigned WIDTH = 65,
  parameter int unsigned DEPTH = 512
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### hw/rtl/trap_reaction_selector_core.sv
// trap_reaction_selector_core: direct-method reaction choice over a site table
// throughput: one transaction at a time; an event walks the site ram one entry per cycle
// reset: synchronous active-low; afterwards a clearing pass zeroes the site ram, during
// which no input transaction is taken (config writes still are)
// depends on trs_pkg and trs_ram
`default_nettype none

module trap_reaction_selector_core
  import trs_pkg::*;
#(
  parameter int unsigned SITE_DEPTH = 512,
  parameter int unsigned RATE_BITS  = 32
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  // input channel
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic                     in_operation,
  input  wire logic [SITE_FIELD_W-1:0]  in_site_index,
  input  wire logic [RATE_FIELD_W-1:0]  in_capture_rate_in,
  input  wire logic [RATE_FIELD_W-1:0]  in_emission_rate_in,
  input  wire logic [FRAC_W-1:0]        in_random_fraction,
  // result channel
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic                          out_fired,
  output logic                          out_captured,
  output logic      [SITE_FIELD_W-1:0]  out_chosen_site,
  output logic      [COUNT_FIELD_W-1:0] out_charged_total,
  // configuration port
  input  wire logic                     psel,
  input  wire logic                     penable,
  input  wire logic                     pwrite,
  input  wire logic [CFG_ADDR_W-1:0]    paddr,
  input  wire logic [CFG_DATA_W-1:0]    pwdata,
  output logic      [CFG_DATA_W-1:0]    prdata,
  output logic                          pready
);

  // widths derived from the table size and rate precision
  localparam int unsigned IDX_W  = $clog2(SITE_DEPTH);
  localparam int unsigned CNT_W  = $clog2(SITE_DEPTH + 1);
  localparam int unsigned SUM_W  = RATE_BITS + IDX_W;
  localparam int unsigned TOT_W  = (SUM_W + 1 > 64) ? 64 : SUM_W + 1;
  localparam int unsigned WORD_W = 2 * RATE_BITS + 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SITE_DEPTH - 1);

  // ram word layout: charged flag on top, then emission rate, then capture rate
  localparam int unsigned CAP_LO  = 0;
  localparam int unsigned EMI_LO  = RATE_BITS;
  localparam int unsigned FLAG_B  = 2 * RATE_BITS;

  // ---------------------------------------------------------------------------
  // registers
  // ---------------------------------------------------------------------------
  trs_state_t          state_r, state_nxt;
  logic [9:0]          active_r;
  logic [SUM_W-1:0]    ncs_r, ncs_nxt;      // capture sum over neutral sites
  logic [SUM_W-1:0]    ces_r, ces_nxt;      // emission sum over charged sites
  logic [CNT_W-1:0]    count_r, count_nxt;  // number of charged sites
  logic [IDX_W-1:0]    clr_cnt_r, clr_cnt_nxt;

  // latched input transaction
  logic                op_r;
  logic                ld_ok_r;
  logic [IDX_W-1:0]    idx_r;
  logic [RATE_BITS-1:0] cap_r, emi_r;
  logic [FRAC_W-1:0]   u_r;

  // threshold computation
  logic [63:0]         prod_r, prod_nxt;
  logic [31:0]         part_r, part_nxt;
  logic [TOT_W-1:0]    thr_r, thr_nxt;
  logic [TOT_W-1:0]    run_r, run_nxt;
  logic                emit_side_r, emit_side_nxt;

  // scan pipeline
  logic [CNT_W-1:0]    issue_cnt_r, issue_cnt_nxt;
  logic                chk_v_r;
  logic [IDX_W-1:0]    chk_idx_r;
  logic [IDX_W-1:0]    hit_idx_r, hit_idx_nxt;
  logic [WORD_W-1:0]   hit_word_r, hit_word_nxt;

  // pending result
  logic                res_fired_r, res_fired_nxt;
  logic                res_captured_r, res_captured_nxt;
  logic [IDX_W-1:0]    res_site_r, res_site_nxt;

  // output register
  logic                out_valid_r;
  logic                out_fired_r, out_captured_r;
  logic [SITE_FIELD_W-1:0]  out_site_r;
  logic [COUNT_FIELD_W-1:0] out_total_r;

  // ---------------------------------------------------------------------------
  // site ram
  // ---------------------------------------------------------------------------
  logic                ram_we, ram_re;
  logic [IDX_W-1:0]    ram_waddr, ram_raddr;
  logic [WORD_W-1:0]   ram_wdata, ram_rdata;

  trs_ram #(
    .WIDTH (WORD_W),
    .DEPTH (SITE_DEPTH)
  ) u_site_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // ---------------------------------------------------------------------------
  // configuration port: single register, index taken from paddr[2]
  // ---------------------------------------------------------------------------
  logic cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite &&
                  (paddr[CFG_ADDR_W-1] == REG_ACTIVE_SITES);
  assign prdata = (paddr[CFG_ADDR_W-1] == REG_ACTIVE_SITES) ?
                  CFG_DATA_W'(active_r) : '0;

  // ---------------------------------------------------------------------------
  // combinational helpers
  // ---------------------------------------------------------------------------
  logic              in_acc;
  logic [CNT_W-1:0]  scan_n;
  logic [63:0]       tot64;
  logic [31:0]       mul_b;
  logic [63:0]       mul_p;
  logic [63:0]       thr64;
  logic [TOT_W-1:0]  thr_full;

  // old and new entry fields
  logic              rd_flag;
  logic [RATE_BITS-1:0] rd_cap, rd_emi, rd_rate;
  logic              rd_match, scan_hit, scan_done;
  logic [TOT_W-1:0]  run_add;

  logic              hit_flag;
  logic [RATE_BITS-1:0] hit_cap, hit_emi;

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;

  // scanned sites are clipped to the table
  always_comb begin
    if (32'(active_r) > 32'(SITE_DEPTH)) begin
      scan_n = CNT_W'(SITE_DEPTH);
    end else begin
      scan_n = CNT_W'(active_r);
    end
  end

  // total rate; the threshold is floor(u * total / 2^32), built from two
  // 32x32 products on one shared multiplier
  assign tot64    = 64'(ncs_r) + 64'(ces_r);
  assign mul_b    = (state_r == ST_MUL_HI) ? tot64[63:32] : tot64[31:0];
  assign mul_p    = 64'(u_r) * 64'(mul_b);
  assign thr64    = prod_r + {32'b0, part_r};
  assign thr_full = thr64[TOT_W-1:0];

  assign rd_flag  = ram_rdata[FLAG_B];
  assign rd_cap   = ram_rdata[CAP_LO +: RATE_BITS];
  assign rd_emi   = ram_rdata[EMI_LO +: RATE_BITS];
  assign rd_match = (rd_flag == emit_side_r);
  assign rd_rate  = emit_side_r ? rd_emi : rd_cap;
  assign run_add  = run_r + TOT_W'(rd_rate);
  assign scan_hit = chk_v_r && rd_match && (thr_r < run_add);
  assign scan_done = (issue_cnt_r == scan_n) && !chk_v_r;

  assign hit_flag = hit_word_r[FLAG_B];
  assign hit_cap  = hit_word_r[CAP_LO +: RATE_BITS];
  assign hit_emi  = hit_word_r[EMI_LO +: RATE_BITS];

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt        = state_r;
    ncs_nxt          = ncs_r;
    ces_nxt          = ces_r;
    count_nxt        = count_r;
    clr_cnt_nxt      = clr_cnt_r;
    prod_nxt         = prod_r;
    part_nxt         = part_r;
    thr_nxt          = thr_r;
    run_nxt          = run_r;
    emit_side_nxt    = emit_side_r;
    issue_cnt_nxt    = issue_cnt_r;
    hit_idx_nxt      = hit_idx_r;
    hit_word_nxt     = hit_word_r;
    res_fired_nxt    = res_fired_r;
    res_captured_nxt = res_captured_r;
    res_site_nxt     = res_site_r;
    ram_we           = 1'b0;
    ram_waddr        = idx_r;
    ram_wdata        = '0;
    ram_re           = 1'b0;
    ram_raddr        = idx_r;

    unique case (state_r)
      // zero the site ram after reset
      ST_CLEAR: begin
        ram_we      = 1'b1;
        ram_waddr   = clr_cnt_r;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == LAST_IDX) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_acc) begin
          res_fired_nxt    = 1'b0;
          res_captured_nxt = 1'b0;
          res_site_nxt     = '0;
          if (in_operation == OP_LOAD) begin
            state_nxt = ST_LD_RD;
          end else begin
            state_nxt = ST_MUL_LO;
          end
        end
      end

      // read the old entry of the loaded site
      ST_LD_RD: begin
        if (ld_ok_r) begin
          ram_re    = 1'b1;
          state_nxt = ST_LD_WR;
        end else begin
          state_nxt = ST_EMIT;
        end
      end

      // write the new rates, keep the flag, correct the matching total
      ST_LD_WR: begin
        ram_we    = 1'b1;
        ram_wdata = {rd_flag, emi_r, cap_r};
        if (rd_flag) begin
          ces_nxt = ces_r - SUM_W'(rd_emi) + SUM_W'(emi_r);
        end else begin
          ncs_nxt = ncs_r - SUM_W'(rd_cap) + SUM_W'(cap_r);
        end
        state_nxt = ST_EMIT;
      end

      // low half of u * total; nothing fires on a zero total
      ST_MUL_LO: begin
        prod_nxt = mul_p;
        if (tot64 == 64'd0) begin
          state_nxt = ST_EMIT;
        end else begin
          state_nxt = ST_MUL_HI;
        end
      end

      // high half; keep the top of the low product for the final add
      ST_MUL_HI: begin
        part_nxt  = prod_r[63:32];
        prod_nxt  = mul_p;
        state_nxt = ST_THR;
      end

      // threshold, side of the rate line and starting sum
      ST_THR: begin
        thr_nxt       = thr_full;
        emit_side_nxt = (thr_full < TOT_W'(ces_r));
        run_nxt       = (thr_full < TOT_W'(ces_r)) ? '0 : TOT_W'(ces_r);
        issue_cnt_nxt = '0;
        state_nxt     = ST_SCAN;
      end

      // one ram read issued and one entry checked per cycle
      ST_SCAN: begin
        if (issue_cnt_r != scan_n) begin
          ram_re        = 1'b1;
          ram_raddr     = issue_cnt_r[IDX_W-1:0];
          issue_cnt_nxt = issue_cnt_r + 1'b1;
        end
        if (chk_v_r && rd_match) begin
          run_nxt = run_add;
        end
        if (scan_hit) begin
          hit_idx_nxt  = chk_idx_r;
          hit_word_nxt = ram_rdata;
          state_nxt    = ST_FLIP;
        end else if (scan_done) begin
          state_nxt = ST_EMIT;
        end
      end

      // flip the chosen site and move its rates between the totals
      ST_FLIP: begin
        ram_we           = 1'b1;
        ram_waddr        = hit_idx_r;
        ram_wdata        = {~hit_flag, hit_emi, hit_cap};
        res_fired_nxt    = 1'b1;
        res_site_nxt     = hit_idx_r;
        if (emit_side_r) begin
          ces_nxt          = ces_r - SUM_W'(hit_emi);
          ncs_nxt          = ncs_r + SUM_W'(hit_cap);
          res_captured_nxt = 1'b0;
          if (count_r != '0) begin
            count_nxt = count_r - 1'b1;
          end
        end else begin
          ncs_nxt          = ncs_r - SUM_W'(hit_cap);
          ces_nxt          = ces_r + SUM_W'(hit_emi);
          res_captured_nxt = 1'b1;
          count_nxt        = count_r + 1'b1;
        end
        state_nxt = ST_EMIT;
      end

      // hand the result to the output register once it is free
      ST_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // control registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      active_r    <= ACTIVE_SITES_RST;
      ncs_r       <= '0;
      ces_r       <= '0;
      count_r     <= '0;
      clr_cnt_r   <= '0;
      chk_v_r     <= 1'b0;
      issue_cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ncs_r       <= ncs_nxt;
      ces_r       <= ces_nxt;
      count_r     <= count_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      chk_v_r     <= ram_re && (state_r == ST_SCAN);
      issue_cnt_r <= issue_cnt_nxt;
      if (cfg_wr) begin
        active_r <= pwdata[9:0];
      end
      if ((state_r == ST_EMIT) && (!out_valid_r || !out_stall)) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // payload registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r    <= in_operation;
      ld_ok_r <= (32'(in_site_index) < 32'(SITE_DEPTH));
      idx_r   <= IDX_W'(in_site_index);
      cap_r   <= RATE_BITS'(in_capture_rate_in);
      emi_r   <= RATE_BITS'(in_emission_rate_in);
      u_r     <= in_random_fraction;
    end
    prod_r         <= prod_nxt;
    part_r         <= part_nxt;
    thr_r          <= thr_nxt;
    run_r          <= run_nxt;
    emit_side_r    <= emit_side_nxt;
    chk_idx_r      <= ram_raddr;
    hit_idx_r      <= hit_idx_nxt;
    hit_word_r     <= hit_word_nxt;
    res_fired_r    <= res_fired_nxt && (op_r == OP_EVENT);
    res_captured_r <= res_captured_nxt;
    res_site_r     <= res_site_nxt;
    if ((state_r == ST_EMIT) && (!out_valid_r || !out_stall)) begin
      out_fired_r    <= res_fired_r;
      out_captured_r <= res_captured_r;
      out_site_r     <= SITE_FIELD_W'(res_site_r);
      out_total_r    <= COUNT_FIELD_W'(count_r);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_fired         = out_fired_r;
  assign out_captured      = out_captured_r;
  assign out_chosen_site   = out_site_r;
  assign out_charged_total = out_total_r;

endmodule

`default_nettype wire

### dv/tb_top.sv
`timescale 1ns / 100ps
// tb_top: self-checking bench for trap_reaction_selector_core, load and reaction event traffic
// tracks site rates, charged flags and running totals alongside the core; needs trs_pkg,
// trs_ram and the core rtl only

import trs_pkg::*;

localparam int unsigned TB_SITES = 512;

typedef struct packed {
  logic                     op;
  logic [SITE_FIELD_W-1:0]  site;
  logic [RATE_FIELD_W-1:0]  cap;
  logic [RATE_FIELD_W-1:0]  emi;
  logic [FRAC_W-1:0]        frac;
} site_item_t;

typedef struct packed {
  logic                     fired;
  logic                     captured;
  logic [SITE_FIELD_W-1:0]  site;
  logic [COUNT_FIELD_W-1:0] charged;
} reaction_t;

// shadow of the site table plus the queue of reactions still owed by the core
class reaction_tracker;
  logic [RATE_FIELD_W-1:0]  cap_rate [TB_SITES];
  logic [RATE_FIELD_W-1:0]  emi_rate [TB_SITES];
  logic                     charged  [TB_SITES];
  logic [63:0]              neutral_sum;
  logic [63:0]              charged_sum;
  logic [COUNT_FIELD_W-1:0] charged_count;
  logic [COUNT_FIELD_W-1:0] active_sites;
  reaction_t                awaited[$];
  int unsigned              fails, loads, events, captures, emissions, checked;

  function new();
    foreach (cap_rate[i]) begin
      cap_rate[i] = '0;
      emi_rate[i] = '0;
      charged[i]  = 1'b0;
    end
    neutral_sum   = '0;
    charged_sum   = '0;
    charged_count = '0;
    active_sites  = ACTIVE_SITES_RST;
    fails = 0; loads = 0; events = 0; captures = 0; emissions = 0; checked = 0;
  endfunction

  // one direct-method step: emission line of charged sites, then capture line of neutral ones
  function reaction_t choose_reaction(site_item_t it);
    reaction_t   r;
    logic [79:0] product;
    logic [63:0] total, thr, run;
    logic        emit_side;
    int          scan;
    r = '0;
    if (it.op == OP_LOAD) begin
      if (charged[it.site]) charged_sum = charged_sum - emi_rate[it.site] + it.emi;
      else neutral_sum = neutral_sum - cap_rate[it.site] + it.cap;
      cap_rate[it.site] = it.cap;
      emi_rate[it.site] = it.emi;
    end else begin
      total = neutral_sum + charged_sum;
      scan  = (active_sites > TB_SITES) ? TB_SITES : active_sites;
      if (total != 0) begin
        product   = 80'(it.frac) * 80'(total);
        thr       = 64'(product >> 32);
        emit_side = (thr < charged_sum);
        run       = emit_side ? 64'd0 : charged_sum;
        for (int i = 0; i < scan && !r.fired; i++) begin
          if (charged[i] == emit_side) begin
            run = run + (emit_side ? 64'(emi_rate[i]) : 64'(cap_rate[i]));
            if (thr < run) begin
              if (emit_side) begin
                charged[i]  = 1'b0;
                charged_sum = charged_sum - emi_rate[i];
                neutral_sum = neutral_sum + cap_rate[i];
                if (charged_count > 0) charged_count = charged_count - 1'b1;
              end else begin
                charged[i]    = 1'b1;
                neutral_sum   = neutral_sum - cap_rate[i];
                charged_sum   = charged_sum + emi_rate[i];
                charged_count = charged_count + 1'b1;
              end
              r.fired    = 1'b1;
              r.captured = !emit_side;
              r.site     = SITE_FIELD_W'(i);
            end
          end
        end
      end
    end
    r.charged = charged_count;
    return r;
  endfunction

  function void note_item(site_item_t it);
    if (it.op == OP_LOAD) loads++;
    else events++;
    awaited = {awaited, choose_reaction(it)};
  endfunction

  task report(string what);
    if (fails < 40) $display("mismatch: %s", what);
    fails++;
  endtask

  task check_reaction(reaction_t got);
    reaction_t want;
    if (awaited.size() == 0) begin
      report("result transaction with nothing awaited");
      return;
    end
    want = awaited.pop_front();
    checked++;
    if (got.fired !== want.fired)
      report($sformatf("#%0d fired %b, awaited %b", checked, got.fired, want.fired));
    if (got.captured !== want.captured)
      report($sformatf("#%0d captured %b, awaited %b", checked, got.captured, want.captured));
    if (got.site !== want.site)
      report($sformatf("#%0d chosen site %0d, awaited %0d", checked, got.site, want.site));
    if (got.charged !== want.charged)
      report($sformatf("#%0d charged total %0d, awaited %0d", checked, got.charged,
                       want.charged));
    if (want.fired) begin
      if (want.captured) captures++;
      else emissions++;
    end
  endtask
endclass

module tb_top;

  localparam logic [CFG_ADDR_W-1:0] ADDR_ACTIVE_SITES = {REG_ACTIVE_SITES, 2'b00};
  // first address past the register list, writes there must leave the core untouched
  localparam logic [CFG_ADDR_W-1:0] ADDR_SPARE        = {~REG_ACTIVE_SITES, 2'b00};
  localparam int unsigned PHASES     = 10;
  localparam int unsigned PHASE_ITEMS = 115;

  logic clk = 1'b0;
  logic rst_n;

  logic                     in_valid;
  logic                     in_stall;
  logic                     in_operation;
  logic [SITE_FIELD_W-1:0]  in_site_index;
  logic [RATE_FIELD_W-1:0]  in_capture_rate_in;
  logic [RATE_FIELD_W-1:0]  in_emission_rate_in;
  logic [FRAC_W-1:0]        in_random_fraction;

  logic                     out_valid;
  logic                     out_stall;
  logic                     out_fired;
  logic                     out_captured;
  logic [SITE_FIELD_W-1:0]  out_chosen_site;
  logic [COUNT_FIELD_W-1:0] out_charged_total;

  logic                     psel;
  logic                     penable;
  logic                     pwrite;
  logic [CFG_ADDR_W-1:0]    paddr;
  logic [CFG_DATA_W-1:0]    pwdata;
  logic [CFG_DATA_W-1:0]    prdata;
  logic                     pready;

  reaction_tracker tracker = new;
  site_item_t      plan[$];
  // when set, neither side inserts gaps or stalls
  bit              steady = 1'b0;

  trap_reaction_selector_core #(
    .SITE_DEPTH(TB_SITES),
    .RATE_BITS (32)
  ) uut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // hard stop in case a handshake never completes
  initial begin
    #60_000_000;
    $display("status: fail");
    $finish;
  end

  function automatic int draw_wait();
    return steady ? 0 : $urandom_range(18, 0);
  endfunction

  // rates lean on zero, all ones and small values so sums stay readable and still wrap wide
  function automatic logic [RATE_FIELD_W-1:0] draw_rate();
    case ($urandom_range(9, 0))
      0:       return '0;
      1:       return '1;
      2:       return RATE_FIELD_W'($urandom_range(15, 0));
      3, 4:    return RATE_FIELD_W'($urandom_range(65535, 0));
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [FRAC_W-1:0] draw_fraction();
    case ($urandom_range(9, 0))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic site_item_t load_item(int site, logic [31:0] cap, logic [31:0] emi);
    site_item_t it;
    it.op   = OP_LOAD;
    it.site = SITE_FIELD_W'(site);
    it.cap  = cap;
    it.emi  = emi;
    it.frac = $urandom;
    return it;
  endfunction

  function automatic site_item_t event_item(logic [31:0] frac);
    site_item_t it;
    it.op   = OP_EVENT;
    it.site = SITE_FIELD_W'($urandom);
    it.cap  = $urandom;
    it.emi  = $urandom;
    it.frac = frac;
    return it;
  endfunction

  // warm-up items are mostly loads into the scanned range so that events have work to do
  function automatic site_item_t draw_item(int span, bit warmup);
    site_item_t it;
    it.site = SITE_FIELD_W'($urandom);
    if (span > 0 && $urandom_range(4, 0) != 0)
      it.site = SITE_FIELD_W'($urandom_range(span - 1, 0));
    it.cap  = draw_rate();
    it.emi  = draw_rate();
    it.frac = draw_fraction();
    it.op   = ($urandom_range(99, 0) < (warmup ? 85 : 40)) ? OP_LOAD : OP_EVENT;
    return it;
  endfunction

  // appends one transaction to the plan
  function automatic void enqueue(input site_item_t it);
    plan = {plan, it};
  endfunction

  // presents one transaction and returns at the edge that accepts it
  task automatic send_item(input site_item_t it);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid            <= 1'b1;
    in_operation        <= it.op;
    in_site_index       <= it.site;
    in_capture_rate_in  <= it.cap;
    in_emission_rate_in <= it.emi;
    in_random_fraction  <= it.frac;
    do @(posedge clk); while (in_stall !== 1'b0);
  endtask

  task automatic drive_plan();
    foreach (plan[n]) begin
      // toggle between gappy and back-to-back stretches
      if (n % 30 == 0) steady = ($urandom_range(3, 0) == 0);
      send_item(plan[n]);
    end
    in_valid <= 1'b0;
    plan.delete();
  endtask

  // skips the accepting edge so the input monitor has logged the last transaction
  task automatic wait_drained();
    do @(posedge clk); while (tracker.awaited.size() != 0);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [CFG_DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == ADDR_ACTIVE_SITES) tracker.active_sites = data[COUNT_FIELD_W-1:0];
  endtask

  // both monitors look at pre-edge values, so the order within the time step does not matter
  always @(posedge clk) begin
    if (rst_n === 1'b1 && in_valid === 1'b1 && in_stall === 1'b0)
      tracker.note_item({in_operation, in_site_index, in_capture_rate_in,
                         in_emission_rate_in, in_random_fraction});
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
      tracker.check_reaction({out_fired, out_captured, out_chosen_site, out_charged_total});
  end

  // result side: per transaction, hold stall for a drawn number of edges once valid shows
  initial begin : result_sink
    int hold;
    out_stall <= 1'b0;
    do @(posedge clk); while (rst_n !== 1'b1);
    forever begin
      hold = draw_wait();
      out_stall <= (hold != 0);
      do @(posedge clk); while (out_valid !== 1'b1);
      if (hold != 0) begin
        repeat (hold - 1) @(posedge clk);
        out_stall <= 1'b0;
        @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    logic [CFG_DATA_W-1:0] word;
    int unsigned           settings[PHASES];
    int                    span;
    rst_n               <= 1'b0;
    in_valid            <= 1'b0;
    in_operation        <= OP_LOAD;
    in_site_index       <= '0;
    in_capture_rate_in  <= '0;
    in_emission_rate_in <= '0;
    in_random_fraction  <= '0;
    psel                <= 1'b0;
    penable             <= 1'b0;
    pwrite              <= 1'b0;
    paddr               <= '0;
    pwdata              <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed part at the reset site range; the core's clearing pass holds off the first
    enqueue(event_item(32'h8000_0000));          // empty table, nothing can fire
    enqueue(load_item(0, '1, '1));
    enqueue(load_item(511, 1, 0));
    enqueue(event_item('0));                     // lowest threshold, first neutral site
    enqueue(event_item('1));                     // threshold lands on the last site
    enqueue(load_item(0, 0, 5));                 // reload of a charged site
    enqueue(event_item('0));                     // emission side
    enqueue(event_item('1));                     // totals zero with a site still charged
    enqueue(load_item(511, 7, 0));
    enqueue(load_item(100, 32'h8000_0000, 1));
    enqueue(load_item(200, 32'h1234_5678, '1));
    enqueue(load_item(300, '1, 2));
    enqueue(event_item('1));
    enqueue(event_item(32'h8000_0000));
    enqueue(event_item('0));
    enqueue(event_item('1));
    enqueue(event_item($urandom));
    enqueue(load_item(200, 0, 0));
    enqueue(event_item(32'h4000_0000));
    drive_plan();
    wait_drained();

    // site-range settings: reset value, smallest, none, over-range, and a few in between
    settings = '{512, 1, 0, 1023, 2, 8, 16, 64, 256, 512};
    settings[6] = $urandom_range(40, 3);
    settings[8] = $urandom_range(511, 9);
    for (int p = 0; p < PHASES; p++) begin
      word = $urandom;
      if (p == 0) begin
        // write past the register list while the reset range stays in force
        write_reg(ADDR_SPARE, word);
      end else begin
        word[COUNT_FIELD_W-1:0] = COUNT_FIELD_W'(settings[p]);
        write_reg(ADDR_ACTIVE_SITES, word);
      end
      span = (settings[p] > TB_SITES) ? TB_SITES : settings[p];
      for (int n = 0; n < PHASE_ITEMS; n++) enqueue(draw_item(span, n < 25));
      drive_plan();
      wait_drained();
    end

    // quiet window longer than a full-table scan to catch stray results
    steady = 1'b1;
    repeat (600) @(posedge clk);
    if (tracker.awaited.size() != 0) tracker.report("results still awaited at the end");

    $display("covered %0d rate loads and %0d reaction events over %0d site-range settings",
             tracker.loads, tracker.events, PHASES + 1);
    $display("%0d results checked: %0d captures, %0d emissions, %0d mismatches",
             tracker.checked, tracker.captures, tracker.emissions, tracker.fails);
    if (tracker.fails == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
